[rtl/core/cursor_line_edit_buffer_core_macros.svh]
// Assertion macros used by the cursor line-edit buffer RTL.
`ifndef CURSOR_LINE_EDIT_BUFFER_CORE_MACROS_SVH
`define CURSOR_LINE_EDIT_BUFFER_CORE_MACROS_SVH

// Property holds on every clock edge outside reset.
`define CLEB_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle.
`define CLEB_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/clebc_pkg.sv]
// Types and constants for the cursor line-edit buffer.
package clebc_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int QDEPTH = 2;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   localparam logic [2:0] KIND_LEFT   = 3'd0;
   localparam logic [2:0] KIND_RIGHT  = 3'd1;
   localparam logic [2:0] KIND_BACK   = 3'd2;
   localparam logic [2:0] KIND_INSERT = 3'd3;
   localparam logic [2:0] KIND_READ   = 3'd4;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last;
      logic       empty_res;
      logic       dropped;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_LEFT,
      OP_RIGHT,
      OP_BACK,
      OP_INSERT,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] character;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE,
      ST_RD_ADDR,
      ST_RD_DATA
   } state_type;

   function automatic op_type kind_to_op(input logic [2:0] kind);
      op_type op;
      case (kind)
         KIND_LEFT:   op = OP_LEFT;
         KIND_RIGHT:  op = OP_RIGHT;
         KIND_BACK:   op = OP_BACK;
         KIND_INSERT: op = OP_INSERT;
         default:     op = OP_READ;
      endcase
      return op;
   endfunction

endpackage

[rtl/core/clebc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module clebc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/clebc_front.sv]
// Front end: accepts request beats, classifies them and queues commands.
module clebc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  clebc_pkg::req_type req_data,
   output logic              cmd_valid,
   output clebc_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import clebc_pkg::*;

   cmd_type          q_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             kind_ok;
   logic             enq;
   logic             deq;

   assign full      = (count_ff == QCW'(QDEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign kind_ok   = req_data.kind inside {[KIND_LEFT:KIND_READ]};
   assign enq       = push && !full && kind_ok;
   assign deq       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      case ({enq, deq})
         2'b10:   count_in = count_ff + QCW'(1);
         2'b01:   count_in = count_ff - QCW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= '{op: kind_to_op(req_data.kind), character: req_data.character};
      end
   end

endmodule

[rtl/core/clebc_back.sv]
// Back end: executes queued commands on the two character stacks.
`include "cursor_line_edit_buffer_core_macros.svh"

module clebc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  clebc_pkg::cmd_type cmd,
   output logic               cmd_pop,
   output logic               empty,
   input  logic               pop,
   output clebc_pkg::rsp_type rsp_data
);
   import clebc_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  lc_ff, lc_in;
   logic [CNT_W-1:0]  rc_ff, rc_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_right_ff, rd_right_in;
   logic              rd_last_ff, rd_last_in;
   logic              mv_left_ff, mv_left_in;
   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic [CNT_W-1:0]  total;
   logic [CNT_W-1:0]  lc_dec;
   logic [CNT_W-1:0]  rc_dec;
   logic [CNT_W-1:0]  rd_rev;
   logic              out_free;

   logic              l_we, l_re, r_we, r_re;
   logic [ADDR_W-1:0] l_waddr, l_raddr, r_waddr, r_raddr;
   logic [7:0]        l_wdata, r_wdata, l_rdata, r_rdata;

   assign total    = lc_ff + rc_ff;
   assign lc_dec   = lc_ff - CNT_W'(1);
   assign rc_dec   = rc_ff - CNT_W'(1);
   assign rd_rev   = total - CNT_W'(1) - rd_idx_ff;
   assign out_free = !out_valid_ff || pop;
   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   clebc_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_left_ram (
      .clock (clock),
      .we    (l_we),
      .waddr (l_waddr),
      .wdata (l_wdata),
      .re    (l_re),
      .raddr (l_raddr),
      .rdata (l_rdata)
   );

   clebc_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_right_ram (
      .clock (clock),
      .we    (r_we),
      .waddr (r_waddr),
      .wdata (r_wdata),
      .re    (r_re),
      .raddr (r_raddr),
      .rdata (r_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  OP_LEFT:  if (lc_ff != '0) state_in = ST_MOVE;
                  OP_RIGHT: if (rc_ff != '0) state_in = ST_MOVE;
                  OP_READ:  if (total != '0) state_in = ST_RD_ADDR;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_MOVE:    state_in = ST_IDLE;
         ST_RD_ADDR: state_in = ST_RD_DATA;
         ST_RD_DATA: begin
            if (out_free) begin
               state_in = rd_last_ff ? ST_IDLE : ST_RD_ADDR;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop      = 1'b0;
      lc_in        = lc_ff;
      rc_in        = rc_ff;
      ovf_in       = ovf_ff;
      rd_idx_in    = rd_idx_ff;
      rd_right_in  = rd_right_ff;
      rd_last_in   = rd_last_ff;
      mv_left_in   = mv_left_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop;
      l_we    = 1'b0;
      l_re    = 1'b0;
      r_we    = 1'b0;
      r_re    = 1'b0;
      l_waddr = lc_ff[ADDR_W-1:0];
      l_wdata = cmd.character;
      l_raddr = lc_dec[ADDR_W-1:0];
      r_waddr = rc_ff[ADDR_W-1:0];
      r_wdata = l_rdata;
      r_raddr = rc_dec[ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  OP_LEFT: begin
                     cmd_pop    = 1'b1;
                     mv_left_in = 1'b1;
                     l_re       = (lc_ff != '0);
                  end
                  OP_RIGHT: begin
                     cmd_pop    = 1'b1;
                     mv_left_in = 1'b0;
                     r_re       = (rc_ff != '0);
                  end
                  OP_BACK: begin
                     cmd_pop = 1'b1;
                     if (lc_ff != '0) begin
                        lc_in = lc_dec;
                     end
                  end
                  OP_INSERT: begin
                     cmd_pop = 1'b1;
                     if (total >= CNT_W'(CAPACITY)) begin
                        ovf_in = 1'b1;
                     end else begin
                        l_we  = 1'b1;
                        lc_in = lc_ff + CNT_W'(1);
                     end
                  end
                  default: begin
                     if (total != '0) begin
                        cmd_pop   = 1'b1;
                        rd_idx_in = '0;
                     end else if (out_free) begin
                        cmd_pop      = 1'b1;
                        out_in       = '{text_byte: 8'd0, last: 1'b1, empty_res: 1'b1,
                                         dropped: ovf_ff};
                        out_valid_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_MOVE: begin
            if (mv_left_ff) begin
               r_we    = 1'b1;
               r_wdata = l_rdata;
               lc_in   = lc_dec;
               rc_in   = rc_ff + CNT_W'(1);
            end else begin
               l_we    = 1'b1;
               l_wdata = r_rdata;
               rc_in   = rc_dec;
               lc_in   = lc_ff + CNT_W'(1);
            end
         end
         ST_RD_ADDR: begin
            rd_last_in = (rd_idx_ff == total - CNT_W'(1));
            if (rd_idx_ff < lc_ff) begin
               rd_right_in = 1'b0;
               l_re        = 1'b1;
               l_raddr     = rd_idx_ff[ADDR_W-1:0];
            end else begin
               rd_right_in = 1'b1;
               r_re        = 1'b1;
               r_raddr     = rd_rev[ADDR_W-1:0];
            end
         end
         ST_RD_DATA: begin
            if (out_free) begin
               out_in       = '{text_byte: rd_right_ff ? r_rdata : l_rdata, last: rd_last_ff,
                                empty_res: 1'b0, dropped: ovf_ff};
               out_valid_in = 1'b1;
               rd_idx_in    = rd_idx_ff + CNT_W'(1);
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lc_ff        <= '0;
         rc_ff        <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lc_ff        <= lc_in;
         rc_ff        <= rc_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      rd_right_ff <= rd_right_in;
      rd_last_ff  <= rd_last_in;
      mv_left_ff  <= mv_left_in;
      out_ff      <= out_in;
   end

   `CLEB_ASSERT_ALWAYS(a_fill_bound, clock, reset, (total <= CNT_W'(CAPACITY)), "text exceeds capacity")
   `CLEB_ASSERT_ALWAYS(a_walk_range, clock, reset, (!(state_ff == ST_RD_ADDR || state_ff == ST_RD_DATA) || rd_idx_ff < total), "read-out index past text end")
   `CLEB_ASSERT_ALWAYS(a_pop_idle, clock, reset, (!cmd_pop || (state_ff == ST_IDLE && cmd_valid)), "command taken outside idle")
   `CLEB_ASSERT_ALWAYS(a_one_write, clock, reset, (!(l_we && r_we)), "both stacks written at once")

endmodule

[rtl/core/cursor_line_edit_buffer_core.sv]
// Top level of the cursor line-edit buffer.
// Usage:
//   Request channel: drive req_data with push; a beat is taken on a clock
//   edge with push high and full low. Kinds: cursor left, cursor right,
//   backspace, insert character, read out; other kind codes are discarded.
//   Response channel: while empty is low, rsp_data holds the oldest result;
//   it is taken on an edge with pop high. A read-out gives one beat per
//   character, last set on the final one; an empty text gives one beat
//   with empty_res set. dropped is the sticky full-buffer insert flag.
// Timing:
//   A two-entry command queue sits between intake and execution, so
//   requests keep flowing while the executor works.
//   Backspace and insert execute straight from idle; cursor moves read
//   the source stack, then write through the registered RAM read port.
//   Read-out steps through an address state and a data state per character,
//   set by the registered read port of the stack RAMs, and holds in the
//   data state while the output register is not free.
// Reset clears the queue, both stack counts, the dropped flag and the
// output valid flag; stack contents stay undefined. A stalled receiver
// holds its beat and the executor waits, then the queue fills and full rises.
module cursor_line_edit_buffer_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  clebc_pkg::req_type req_data,
   output logic               empty,
   input  logic               pop,
   output clebc_pkg::rsp_type rsp_data
);
   import clebc_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   clebc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   clebc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/sv/tb_cursor_line_edit_buffer_core.sv]
// Self-checking testbench for the cursor line-edit buffer core.
module tb_cursor_line_edit_buffer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import clebc_pkg::*;

   localparam int TOTAL_ITEMS    = 420;
   localparam int FILL_AT        = 250;
   localparam int SYNC_AT        = 150;
   localparam int HOLDOFF_AT     = 48;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int TAIL_CYCLES    = 200;
   localparam int STALL_LIMIT    = 4000;

   typedef enum {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_TOGGLE} pop_pattern_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   cursor_line_edit_buffer_core u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // command stream and its drain markers
   req_type cmd_q[$];
   bit      sync_q[$];
   int      plan_left   = 0;
   int      plan_right  = 0;
   int      stim_count  = 0;
   bit      sync_placed = 1'b0;

   // line state as the block should hold it
   logic [7:0] line_left_chars  [CAPACITY];
   logic [7:0] line_right_chars [CAPACITY];
   int         line_left_n   = 0;
   int         line_right_n  = 0;
   logic       line_overflow = 1'b0;
   rsp_type    expected_text[$];

   int errors = 0;

   task automatic queue_cmd(input logic [2:0] kind, input logic [7:0] ch);
      req_type cmd;
      cmd.kind      = kind;
      cmd.character = ch;
      cmd_q.push_back(cmd);
      if (!sync_placed && stim_count >= SYNC_AT) begin
         sync_q.push_back(1'b1);
         sync_placed = 1'b1;
      end else begin
         sync_q.push_back(1'b0);
      end
      if (kind <= KIND_READ)
         stim_count++;
      case (kind)
         KIND_LEFT: if (plan_left != 0) begin
            plan_left--;
            plan_right++;
         end
         KIND_RIGHT: if (plan_right != 0) begin
            plan_right--;
            plan_left++;
         end
         KIND_BACK:   if (plan_left != 0) plan_left--;
         KIND_INSERT: if (plan_left + plan_right < CAPACITY) plan_left++;
         default: ;
      endcase
   endtask

   task automatic edit_line(input req_type cmd);
      rsp_type beat;
      int      i;
      beat.dropped = line_overflow;
      case (cmd.kind)
         KIND_LEFT: if (line_left_n != 0 && line_right_n < CAPACITY) begin
            line_left_n--;
            line_right_chars[line_right_n] = line_left_chars[line_left_n];
            line_right_n++;
         end
         KIND_RIGHT: if (line_right_n != 0 && line_left_n < CAPACITY) begin
            line_right_n--;
            line_left_chars[line_left_n] = line_right_chars[line_right_n];
            line_left_n++;
         end
         KIND_BACK: if (line_left_n != 0) line_left_n--;
         KIND_INSERT: begin
            if (line_left_n + line_right_n >= CAPACITY || line_left_n >= CAPACITY) begin
               line_overflow = 1'b1;
            end else begin
               line_left_chars[line_left_n] = cmd.character;
               line_left_n++;
            end
         end
         KIND_READ: begin
            beat.empty_res = 1'b0;
            if (line_left_n + line_right_n == 0) begin
               beat.text_byte = 8'h00;
               beat.last      = 1'b1;
               beat.empty_res = 1'b1;
               expected_text.push_back(beat);
            end else begin
               for (i = 0; i < line_left_n; i++) begin
                  beat.text_byte = line_left_chars[i];
                  beat.last      = (i == line_left_n - 1) && (line_right_n == 0);
                  expected_text.push_back(beat);
               end
               for (i = line_right_n; i > 0; i--) begin
                  beat.text_byte = line_right_chars[i - 1];
                  beat.last      = (i == 1);
                  expected_text.push_back(beat);
               end
            end
         end
         default: ;
      endcase
   endtask

   // sender: bursts and gaps, optional drain before a marked beat
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      logic offer;
      offer = 1'b0;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            edit_line(req_data);
            void'(cmd_q.pop_front());
            void'(sync_q.pop_front());
         end
         if (!(push && full)) begin
            if (gap_left != 0)
               gap_left--;
            else if (cmd_q.size() != 0 && !(sync_q[0] && expected_text.size() != 0))
               offer = 1'b1;
            push <= offer;
            if (offer) begin
               req_data <= cmd_q[0];
               if (burst_left == 0)
                  burst_left = $urandom_range(1, 24);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // receiver: own stall pattern plus one long hold-off
   pop_pattern_type pop_pattern  = POP_ALWAYS;
   int              mode_timer   = 0;
   int              beats_seen   = 0;
   int              holdoff_left = 0;
   bit              holdoff_done = 1'b0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            beats_seen++;
            if (expected_text.size() == 0) begin
               $error("unexpected beat: text_byte %0h last %0b", rsp_data.text_byte,
                      rsp_data.last);
               errors++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_data.text_byte !== want.text_byte) begin
                  $error("text_byte: expected %0h, got %0h", want.text_byte, rsp_data.text_byte);
                  errors++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_data.last);
                  errors++;
               end
               if (rsp_data.empty_res !== want.empty_res) begin
                  $error("empty_res: expected %0b, got %0b", want.empty_res, rsp_data.empty_res);
                  errors++;
               end
               if (rsp_data.dropped !== want.dropped) begin
                  $error("dropped: expected %0b, got %0b", want.dropped, rsp_data.dropped);
                  errors++;
               end
            end
         end
         if (mode_timer == 0) begin
            pop_pattern = pop_pattern_type'($urandom_range(0, 3));
            mode_timer  = $urandom_range(16, 96);
         end else begin
            mode_timer--;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            pop <= 1'b0;
         end else if (!holdoff_done && beats_seen >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            pop <= 1'b0;
         end else begin
            case (pop_pattern)
               POP_ALWAYS: pop <= 1'b1;
               POP_HALF:   pop <= 1'($urandom_range(0, 1));
               POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
               default:    pop <= mode_timer[1];
            endcase
         end
      end
   end

   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("cursor_line_edit_buffer_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int         pick;
      int         n;
      logic [2:0] kind;
      bit         full_done;
      full_done = 1'b0;

      // directed: edges of an empty line, extreme bytes, mid-line insert, spare codes
      queue_cmd(KIND_READ, 8'h00);
      queue_cmd(KIND_LEFT, 8'hFF);
      queue_cmd(KIND_RIGHT, 8'h00);
      queue_cmd(KIND_BACK, 8'hFF);
      queue_cmd(KIND_INSERT, 8'h00);
      queue_cmd(KIND_INSERT, 8'hFF);
      queue_cmd(KIND_INSERT, 8'hA5);
      queue_cmd(KIND_INSERT, 8'h5A);
      queue_cmd(KIND_READ, 8'hFF);
      queue_cmd(KIND_LEFT, 8'h00);
      queue_cmd(KIND_LEFT, 8'h00);
      queue_cmd(KIND_INSERT, 8'h3C);
      queue_cmd(KIND_READ, 8'h00);
      queue_cmd(KIND_RIGHT, 8'h00);
      queue_cmd(KIND_RIGHT, 8'h00);
      queue_cmd(KIND_RIGHT, 8'hFF);
      queue_cmd(KIND_BACK, 8'h00);
      for (int k = KIND_READ + 1; k < 2 ** $bits(KIND_READ); k++)
         queue_cmd(3'(k), 8'hC3);
      queue_cmd(KIND_READ, 8'h00);

      while (stim_count < TOTAL_ITEMS) begin
         if (!full_done && stim_count >= FILL_AT) begin
            // fill to capacity, move inside a full line, then overflow
            while (plan_left + plan_right < CAPACITY)
               queue_cmd(KIND_INSERT, 8'($urandom_range(0, 255)));
            queue_cmd(KIND_READ, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 5)) queue_cmd(KIND_LEFT, 8'($urandom_range(0, 255)));
            queue_cmd(KIND_READ, 8'($urandom_range(0, 255)));
            queue_cmd(KIND_INSERT, 8'($urandom_range(0, 255)));
            queue_cmd(KIND_RIGHT, 8'($urandom_range(0, 255)));
            queue_cmd(KIND_INSERT, 8'($urandom_range(0, 255)));
            queue_cmd(KIND_READ, 8'($urandom_range(0, 255)));
            full_done = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            queue_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
         end else if (pick < 22 || plan_left + plan_right > 40) begin
            repeat ($urandom_range(0, plan_right))
               queue_cmd(KIND_RIGHT, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, plan_left + plan_right + 2))
               queue_cmd(KIND_BACK, 8'($urandom_range(0, 255)));
            queue_cmd(KIND_READ, 8'($urandom_range(0, 255)));
         end else begin
            n = $urandom_range(1, 12);
            if (!full_done && n > CAPACITY - plan_left - plan_right)
               n = CAPACITY - plan_left - plan_right;
            repeat (n) queue_cmd(KIND_INSERT, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(2, 10)) begin
               kind = 3'($urandom_range(KIND_LEFT, KIND_INSERT));
               if (kind == KIND_INSERT && !full_done && plan_left + plan_right >= CAPACITY)
                  kind = KIND_LEFT;
               queue_cmd(kind, 8'($urandom_range(0, 255)));
            end
            queue_cmd(KIND_READ, 8'($urandom_range(0, 255)));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (cmd_q.size() != 0 || push) @(posedge clock);
      while (expected_text.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && expected_text.size() == 0)
         $display("cursor_line_edit_buffer_core: match");
      else
         $display("cursor_line_edit_buffer_core: mismatch");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/clebc_pkg.sv
rtl/core/clebc_ram.sv
rtl/core/clebc_front.sv
rtl/core/clebc_back.sv
rtl/core/cursor_line_edit_buffer_core.sv
tb/sv/tb_cursor_line_edit_buffer_core.sv
